FILE: src/ipv_pkg.sv
// Shared types, character codes and limits for the address text validator.
package ipv_pkg;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_F = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_COLON = 8'h3a;

   localparam logic [11:0] QUAD_MAX    = 12'd255;
   localparam logic [2:0]  QUAD_GROUPS = 3'd4;
   localparam logic [15:0] HEX_SHIFT_LIMIT = 16'h0fff;
   localparam logic [4:0]  ADDR_BYTES  = 5'd16;
   localparam logic [4:0]  GROUP_BYTES = 5'd2;
   localparam logic [4:0]  TAIL_BYTES  = 5'd4;

   // One character step as seen by a checker.
   typedef struct packed {
      logic       advance;  // a character is present and gets consumed
      logic       clear;    // return to the reset state after this step
      logic [7:0] ch;
   } ipv_step_type;

   function automatic logic is_digit(input logic [7:0] ch);
      is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   // bit 4 flags a hex digit, bits 3:0 give its value
   function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
      logic [7:0] diff;
      diff = 8'h00;
      hex_nibble = 5'b00000;
      if (is_digit(ch)) begin
         diff = ch - CH_ZERO;
         hex_nibble = {1'b1, diff[3:0]};
      end else if ((ch >= CH_LOW_A) && (ch <= CH_LOW_F)) begin
         diff = ch - CH_LOW_A + 8'd10;
         hex_nibble = {1'b1, diff[3:0]};
      end else if ((ch >= CH_UP_A) && (ch <= CH_UP_F)) begin
         diff = ch - CH_UP_A + 8'd10;
         hex_nibble = {1'b1, diff[3:0]};
      end
   endfunction

endpackage

FILE: src/ipv_quad_check.sv
// Dotted-quad decimal checker: four groups of at most 255 split by dots.
module ipv_quad_check
   import ipv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ipv_step_type step_i,
   output logic         ok_o
);

   logic [7:0]  value_ff, value_in;
   logic [2:0]  groups_ff, groups_in;
   logic        saw_ff, saw_in;
   logic        failed_ff, failed_in;
   logic [11:0] acc;

   always_comb begin
      value_in  = value_ff;
      groups_in = groups_ff;
      saw_in    = saw_ff;
      failed_in = failed_ff;
      // value * 10 + digit
      acc = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0}
          + {8'h00, step_i.ch[3:0]};
      if (step_i.advance && !failed_ff) begin
         if (is_digit(step_i.ch)) begin
            if (acc > QUAD_MAX) begin
               failed_in = 1'b1;
            end else begin
               value_in = acc[7:0];
               if (!saw_ff) begin
                  if (groups_ff >= QUAD_GROUPS) begin
                     failed_in = 1'b1;
                  end else begin
                     groups_in = groups_ff + 3'd1;
                     saw_in    = 1'b1;
                  end
               end
            end
         end else if ((step_i.ch == CH_DOT) && saw_ff) begin
            if (groups_ff >= QUAD_GROUPS) begin
               failed_in = 1'b1;
            end else begin
               value_in = 8'h00;
               saw_in   = 1'b0;
            end
         end else begin
            failed_in = 1'b1;
         end
      end
   end

   assign ok_o = !failed_in && (groups_in == QUAD_GROUPS);

   always_ff @(posedge clock) begin
      if (reset || step_i.clear) begin
         value_ff  <= 8'h00;
         groups_ff <= 3'd0;
         saw_ff    <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         value_ff  <= value_in;
         groups_ff <= groups_in;
         saw_ff    <= saw_in;
         failed_ff <= failed_in;
      end
   end

endmodule

FILE: src/ipv_six_check.sv
// IPv6 text checker with an embedded dotted-quad tail checker.
module ipv_six_check
   import ipv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ipv_step_type step_i,
   output logic         ok_o
);

   typedef enum logic [1:0] {
      POS_START,  // nothing seen yet
      POS_LEAD,   // leading colon pending
      POS_BODY,   // inside the text
      POS_AFTER   // just after a group-ending colon
   } pos_type;

   pos_type      pos_ff, pos_in;
   logic [15:0]  hex_ff, hex_in;
   logic [4:0]   bytes_ff, bytes_in;
   logic         dc_ff, dc_in;
   logic         hex_saw_ff, hex_saw_in;
   logic         in_tail_ff, in_tail_in;
   logic         failed_ff, failed_in;
   logic         tail_adv;
   logic         tail_restart;
   logic         tail_ok;
   logic [4:0]   nib;
   logic [4:0]   total;
   ipv_step_type tail_step;

   always_comb begin
      pos_in       = pos_ff;
      hex_in       = hex_ff;
      bytes_in     = bytes_ff;
      dc_in        = dc_ff;
      hex_saw_in   = hex_saw_ff;
      in_tail_in   = in_tail_ff;
      failed_in    = failed_ff;
      tail_adv     = 1'b0;
      tail_restart = 1'b0;
      nib          = hex_nibble(step_i.ch);
      if (step_i.advance && !failed_ff) begin
         if (in_tail_ff) begin
            tail_adv = 1'b1;
         end else if ((pos_ff == POS_START) && (step_i.ch == CH_COLON)) begin
            pos_in = POS_LEAD;
         end else if ((pos_ff == POS_LEAD) && (step_i.ch != CH_COLON)) begin
            failed_in = 1'b1;
         end else begin
            pos_in   = POS_BODY;
            tail_adv = 1'b1;
            if (nib[4]) begin
               if (hex_ff > HEX_SHIFT_LIMIT) begin
                  failed_in = 1'b1;
               end else begin
                  hex_in     = {hex_ff[11:0], nib[3:0]};
                  hex_saw_in = 1'b1;
               end
            end else if (step_i.ch == CH_COLON) begin
               tail_restart = 1'b1;
               if (!hex_saw_ff) begin
                  if (dc_ff) failed_in = 1'b1;
                  else dc_in = 1'b1;
               end else begin
                  pos_in = POS_AFTER;
                  if (bytes_ff > ADDR_BYTES - GROUP_BYTES) begin
                     failed_in = 1'b1;
                  end else begin
                     bytes_in   = bytes_ff + GROUP_BYTES;
                     hex_saw_in = 1'b0;
                     hex_in     = 16'h0000;
                  end
               end
            end else if (step_i.ch == CH_DOT) begin
               if (bytes_ff > ADDR_BYTES - TAIL_BYTES) failed_in = 1'b1;
               else in_tail_in = 1'b1;
            end else begin
               failed_in = 1'b1;
            end
         end
      end
   end

   // tail checker restarts at every group start
   always_comb begin
      tail_step.advance = tail_adv;
      tail_step.clear   = tail_restart || step_i.clear;
      tail_step.ch      = step_i.ch;
   end

   ipv_quad_check u_tail (
      .clock  (clock),
      .reset  (reset),
      .step_i (tail_step),
      .ok_o   (tail_ok)
   );

   // verdict on the state after this step
   always_comb begin
      if (in_tail_in) total = bytes_in + TAIL_BYTES;
      else if (hex_saw_in) total = bytes_in + GROUP_BYTES;
      else total = bytes_in;
      ok_o = !failed_in && (pos_in == POS_BODY)
          && (!in_tail_in || tail_ok)
          && !(!in_tail_in && hex_saw_in && (bytes_in > ADDR_BYTES - GROUP_BYTES))
          && (dc_in ? (total != ADDR_BYTES) : (total == ADDR_BYTES));
   end

   always_ff @(posedge clock) begin
      if (reset || step_i.clear) begin
         pos_ff     <= POS_START;
         hex_ff     <= 16'h0000;
         bytes_ff   <= 5'd0;
         dc_ff      <= 1'b0;
         hex_saw_ff <= 1'b0;
         in_tail_ff <= 1'b0;
         failed_ff  <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         hex_ff     <= hex_in;
         bytes_ff   <= bytes_in;
         dc_ff      <= dc_in;
         hex_saw_ff <= hex_saw_in;
         in_tail_ff <= in_tail_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

FILE: src/ip_address_text_validator.sv
// Top level of the address text validator: channel registers and verdict.
//
// Usage:
//   req_*  : one character of address text per transfer. req_char_present
//            low means the transfer carries no byte; req_last marks the end
//            of the string and triggers exactly one verdict.
//   rsp_*  : one verdict per string: rsp_valid_ipv4 (dotted quad),
//            rsp_valid_ipv6 (IPv6 text, only while IPv6 is enabled) and
//            rsp_valid_res, the OR of the two.
//   csr_*  : write of the IPv6 enable bit; always ready. Write it only while
//            no string is in flight.
// Throughput: one character per cycle while no last character waits on a held verdict,
//   set by the character update between the input register and the state registers.
// Verdict path: the last character passes the input register, then the result
//   register, which drives rsp_valid; a held verdict stalls it in the input register.
// Reset: all checker state clears, IPv6 enable is set to 1, no verdict held.
// Stall: while a verdict waits on rsp_ready, plain characters keep flowing;
//   only the next last character waits in the input register.
module ip_address_text_validator
   import ipv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   input  logic       req_char_present,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res,
   output logic       rsp_valid_ipv4,
   output logic       rsp_valid_ipv6,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_ipv6_enable
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_present_ff;
   logic       in_last_ff;

   // result register
   logic       out_valid_ff;
   logic       out_res_ff;
   logic       out_v4_ff;
   logic       out_v6_ff;

   logic       v6_enable_ff;

   logic         process;
   logic         quad_ok;
   logic         six_ok;
   logic         v4_in;
   logic         v6_in;
   ipv_step_type step;

   // A plain character always retires; a last one needs a free result slot.
   assign process   = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;
   assign csr_ready = 1'b1;

   always_comb begin
      step.advance = process && in_present_ff;
      step.clear   = process && in_last_ff;
      step.ch      = in_char_ff;
   end

   ipv_quad_check u_quad (
      .clock  (clock),
      .reset  (reset),
      .step_i (step),
      .ok_o   (quad_ok)
   );

   ipv_six_check u_six (
      .clock  (clock),
      .reset  (reset),
      .step_i (step),
      .ok_o   (six_ok)
   );

   assign v4_in = quad_ok;
   assign v6_in = six_ok && v6_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff    <= req_character;
         in_present_ff <= req_char_present;
         in_last_ff    <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (process && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process && in_last_ff) begin
         out_res_ff <= v4_in || v6_in;
         out_v4_ff  <= v4_in;
         out_v6_ff  <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         v6_enable_ff <= csr_ipv6_enable;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_valid_res  = out_res_ff;
   assign rsp_valid_ipv4 = out_v4_ff;
   assign rsp_valid_ipv6 = out_v6_ff;

`ifndef ASSERT_OFF
   // verdict is the OR of the two checks
   a_res_is_or: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_res_ff == (out_v4_ff || out_v6_ff)))
      else $error("combined verdict differs from its parts");

   // no text is both a dotted quad and IPv6
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_v4_ff && out_v6_ff))
      else $error("string judged both IPv4 and IPv6");

   // a last character blocked by a held verdict stays in the input register
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && out_valid_ff && !rsp_ready)
      |=> (in_valid_ff && in_last_ff && out_valid_ff))
      else $error("last character lost while verdict stalled");

   // reset leaves no verdict pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("registers not empty after reset");
`endif

endmodule
